[rtl/dewt_pkg.sv]
// Shared types, codes, constants and the exp2 factor table of the edge weight table.
package dewt_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_DECAY_MODE = 3'd0;
   localparam logic [2:0] CSR_BOOST      = 3'd1;
   localparam logic [2:0] CSR_CUTOFF     = 3'd2;
   localparam logic [2:0] CSR_DECAY_RATE = 3'd3;
   localparam logic [2:0] CSR_TIME_UNIT  = 3'd4;

   // Forgetting functions
   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_POWER  = 2'd1;
   localparam logic [1:0] MODE_EXP    = 2'd2;

   // Item kinds
   localparam logic [0:0] KIND_QUERY = 1'b1;

   // Fixed-point constants
   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [31:0] LOG2E_Q24  = 32'd24204406;
   localparam logic [40:0] RATE_CAP   = 41'h100_0000_0000;
   localparam logic [40:0] EXP_CAP    = 41'h001_0000_0000;
   localparam logic [16:0] WMAX       = 17'h1FFFF;
   localparam logic [17:0] ERR_WEIGHT = 18'h30000;
   localparam logic [30:0] EXP2_ONE   = 31'h4000_0000;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOOK,
      ST_DIV,
      ST_RATE,
      ST_EXP_MUL,
      ST_NORM,
      ST_LOG_SQ,
      ST_LOG_MUL,
      ST_EXP2,
      ST_EXP2_MUL,
      ST_EXP2_SHIFT,
      ST_SCALE_MUL,
      ST_BLEND,
      ST_BLEND_MUL,
      ST_FINISH,
      ST_WRITE_AB,
      ST_WRITE_BA,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_LOW,
      MUL_DONE
   } mul_phase_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [95:0] p;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [46:0] dividend;
      logic [11:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [46:0] quotient;
   } div_rsp_type;

   typedef logic [29:0] factor_table_type [16];

   // Floor square root, evaluated at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] rem;
      logic [63:0] bit_v;
      r     = '0;
      rem   = x;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + bit_v) begin
            rem = rem - (r + bit_v);
            r   = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   // Entry k holds 2^(-2^(k-16)) in Q0.30, built by successive roots of 0.5
   function automatic factor_table_type exp2_factors();
      factor_table_type tab;
      logic [63:0]      c;
      c = 64'd1 << 29;
      for (int j = 15; j >= 0; j--) begin
         c      = isqrt64(c << 30);
         tab[j] = c[29:0];
      end
      return tab;
   endfunction

endpackage

[rtl/dewt_div.sv]
// Restoring divider, one quotient bit per cycle, for elapsed ticks over the time unit.
module dewt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  dewt_pkg::div_req_type req,
   output dewt_pkg::div_rsp_type rsp
);
   import dewt_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [46:0] q_ff, q_in;
   logic [11:0] rem_ff, rem_in;
   logic [11:0] d_ff, d_in;
   logic [12:0] trial;
   logic [12:0] diff;
   logic        fits;

   assign trial = {rem_ff, q_ff[46]};
   assign diff  = trial - {1'b0, d_ff};
   assign fits  = trial >= {1'b0, d_ff};

   // Shift in one dividend bit, subtract when the divisor fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'($bits(q_ff));
         q_in    = req.dividend;
         rem_in  = '0;
         d_in    = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[11:0] : trial[11:0];
         q_in   = {q_ff[45:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule

[rtl/dewt_mul.sv]
// Shared multiplier: 64 by 32 bit product over two 32 by 32 passes.
module dewt_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  dewt_pkg::mul_req_type req,
   output dewt_pkg::mul_rsp_type rsp
);
   import dewt_pkg::*;

   mul_phase_type phase_ff, phase_in;
   logic [31:0]   a_lo_ff, a_lo_in;
   logic [31:0]   b_ff, b_in;
   logic [95:0]   acc_ff, acc_in;
   logic [31:0]   mul_a;
   logic [31:0]   mul_b;
   logic [63:0]   prod;

   // Upper half on the start cycle, lower half on the next
   assign mul_a = (phase_ff == MUL_LOW) ? a_lo_ff : req.a[63:32];
   assign mul_b = (phase_ff == MUL_LOW) ? b_ff : req.b;
   assign prod  = {32'b0, mul_a} * {32'b0, mul_b};

   always_comb begin
      phase_in = phase_ff;
      a_lo_in  = a_lo_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      case (phase_ff)
         MUL_LOW: begin
            acc_in   = {acc_ff[63:0], 32'b0} + 96'(prod);
            phase_in = MUL_DONE;
         end
         default: begin
            phase_in = MUL_IDLE;
            if (req.start) begin
               acc_in   = 96'(prod);
               a_lo_in  = req.a[31:0];
               b_in     = req.b;
               phase_in = MUL_LOW;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MUL_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      a_lo_ff <= a_lo_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
   end

   assign rsp.done = (phase_ff == MUL_DONE);
   assign rsp.p    = acc_ff;

endmodule

[rtl/decaying_edge_weight_table.sv]
// Edge weight table with forgetting decay: sequencer, edge memory and result register.
//
// Items arrive on the req_ stream: kind in tuser (contact or query), node pair and
// timestamp in tdata. Each item gives exactly one result on the rsp_ stream: the
// weight in tdata and the time error flag in tuser. The user is to write registers
// over the csr_ channel only while the block is idle; the block does not enforce
// this, and it is always ready. One item is handled at a time; req_tready is high
// only in the idle state between items. An item passes the bit-serial divider and,
// by mode, the shared two-pass multiplier; power mode adds a normalize shift, 16
// squarings and up to 16 factors, and with no forgetting function only the divider
// runs. A first contact, a time error and a node out of range skip the divider.
// The sequencer returns to idle for the next item as the result loads. After reset
// the edge memory is swept to zero, one entry per cycle, all NODES*NODES entries
// (4096 at the default), with req_tready low; csr writes are taken meanwhile.
// A finished result waits in the output register while the next item is accepted;
// if the receiver still stalls when that item finishes, the sequencer holds.
module decaying_edge_weight_table #(
   parameter int NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // node_a [5:0], node_b [11:6], event_time [42:12]
   input  logic [0:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // weight [17:0]
   output logic [0:0]  rsp_tuser,   // time_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import dewt_pkg::*;

   localparam int DEPTH = NODES * NODES;
   localparam int AW    = $clog2(DEPTH);
   localparam factor_table_type FACTORS = exp2_factors();

   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;

   // Configuration
   logic [1:0]  mode_ff, mode_in;
   logic [16:0] boost_ff, boost_in;
   logic [15:0] cutoff_ff, cutoff_in;
   logic [31:0] lambda_ff, lambda_in;
   logic [11:0] unit_ff, unit_in;

   // Item and working registers
   logic [0:0]  kind_ff, kind_in;
   logic [5:0]  a_ff, a_in;
   logic [5:0]  b_ff, b_in;
   logic [30:0] now_ff, now_in;
   logic [16:0] w_ff, w_in;
   logic signed [47:0] v_ff, v_in;
   logic [46:0] norm_ff, norm_in;
   logic [5:0]  lead_ff, lead_in;
   logic [15:0] frac_ff, frac_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [33:0] e_ff, e_in;
   logic [30:0] r_ff, r_in;
   logic        neg_ff, neg_in;
   logic [16:0] res_ff, res_in;
   logic        err_ff, err_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [17:0] rsp_weight_ff, rsp_weight_in;
   logic        rsp_err_ff, rsp_err_in;

   // Edge memory: {last contact, weight}
   logic [47:0] mem [DEPTH];
   logic [47:0] mem_q_ff;
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [47:0] mem_wdata;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [31:0] ab_full, ba_full;
   logic [AW-1:0] ab, ba;
   logic        in_range;
   logic [30:0] last_time;
   logic [16:0] stored_w;
   logic [71:0] rate_raw;
   logic [40:0] rate;
   logic [32:0] x_cap;
   logic [31:0] sq;
   logic [30:0] m_next;
   logic [15:0] frac_next;
   logic [20:0] log_val;
   logic [17:0] exp_n;
   logic [30:0] exp2_val;
   logic [47:0] v_mag;
   logic signed [18:0] f;
   logic [16:0] f_mag;
   logic [63:0] blend_ceil;

   dewt_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   dewt_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Entry addresses of both directions
   assign ab_full  = 32'(a_ff) * 32'(NODES) + 32'(b_ff);
   assign ba_full  = 32'(b_ff) * 32'(NODES) + 32'(a_ff);
   assign ab       = ab_full[AW-1:0];
   assign ba       = ba_full[AW-1:0];
   assign in_range = (32'(a_ff) < 32'(NODES)) && (32'(b_ff) < 32'(NODES));

   assign stored_w  = mem_q_ff[16:0];
   assign last_time = mem_q_ff[47:17];

   // Product taps of the shared multiplier
   assign rate_raw  = mul_rsp.p[95:24];
   assign rate      = (rate_raw > 72'(RATE_CAP)) ? RATE_CAP : rate_raw[40:0];
   assign x_cap     = (rate > EXP_CAP) ? EXP_CAP[32:0] : rate[32:0];
   assign sq        = mul_rsp.p[61:30];
   assign m_next    = sq[31] ? sq[31:1] : sq[30:0];
   assign frac_next = {frac_ff[14:0], sq[31]};
   assign log_val   = {5'(lead_ff - 6'd16), frac_next};
   assign exp_n     = e_ff[33:16];
   assign exp2_val  = (exp_n >= 18'd31) ? 31'd0 : (r_ff >> exp_n[4:0]);
   assign v_mag     = v_ff[47] ? 48'(-v_ff) : 48'(v_ff);
   assign f         = $signed({2'b0, ONE_Q16}) - $signed({2'b0, boost_ff});
   assign f_mag     = f[18] ? 17'(-f) : 17'(f);
   assign blend_ceil = mul_rsp.p[63:0] + 64'hFFFF;

   // Sequencer: next state and datapath
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      boost_in      = boost_ff;
      cutoff_in     = cutoff_ff;
      lambda_in     = lambda_ff;
      unit_in       = unit_ff;
      kind_in       = kind_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      now_in        = now_ff;
      w_in          = w_ff;
      v_in          = v_ff;
      norm_in       = norm_ff;
      lead_in       = lead_ff;
      frac_in       = frac_ff;
      cnt_in        = cnt_ff;
      e_in          = e_ff;
      r_in          = r_ff;
      neg_in        = neg_ff;
      res_in        = res_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_weight_in = rsp_weight_ff;
      rsp_err_in    = rsp_err_ff;
      mul_req       = '0;
      div_req       = '0;
      mem_we        = 1'b0;
      mem_addr      = ab;
      mem_wdata     = {now_ff, res_ff};
      req_tready    = 1'b0;
      csr_ready     = 1'b1;

      // Take register writes at any time
      if (csr_valid) begin
         case (csr_index)
            CSR_DECAY_MODE: mode_in   = csr_data[1:0];
            CSR_BOOST:      boost_in  = csr_data[16:0];
            CSR_CUTOFF:     cutoff_in = csr_data[15:0];
            CSR_DECAY_RATE: lambda_in = csr_data;
            CSR_TIME_UNIT:  unit_in   = csr_data[11:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in  = req_tuser;
               a_in     = req_tdata[5:0];
               b_in     = req_tdata[11:6];
               now_in   = req_tdata[42:12];
               err_in   = 1'b0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!in_range) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            w_in = stored_w;
            if (kind_ff != KIND_QUERY && stored_w == '0) begin
               // first contact takes the boost as is
               res_in   = boost_ff;
               state_in = ST_WRITE_AB;
            end else if (now_ff < last_time) begin
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {now_ff - last_time, 16'b0};
               div_req.divisor  = (unit_ff == '0) ? 12'd1 : unit_ff;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               case (mode_ff)
                  MODE_LINEAR, MODE_EXP: begin
                     mul_req.start = 1'b1;
                     mul_req.a     = 64'(div_rsp.quotient);
                     mul_req.b     = lambda_ff;
                     state_in      = ST_RATE;
                  end
                  MODE_POWER: begin
                     if (div_rsp.quotient[46:16] == '0) begin
                        // under one unit: keep the weight, no blend
                        v_in     = $signed(48'(w_ff));
                        state_in = ST_FINISH;
                     end else begin
                        norm_in  = div_rsp.quotient;
                        lead_in  = 6'd46;
                        state_in = ST_NORM;
                     end
                  end
                  default: begin
                     res_in   = '0;
                     state_in = (kind_ff == KIND_QUERY) ? ST_DONE : ST_WRITE_AB;
                  end
               endcase
            end
         end
         ST_RATE: begin
            if (mul_rsp.done) begin
               if (mode_ff == MODE_LINEAR) begin
                  v_in     = $signed(48'(w_ff)) - $signed(48'(rate));
                  state_in = (kind_ff == KIND_QUERY) ? ST_FINISH : ST_BLEND;
               end else begin
                  mul_req.start = 1'b1;
                  mul_req.a     = 64'(x_cap);
                  mul_req.b     = LOG2E_Q24;
                  state_in      = ST_EXP_MUL;
               end
            end
         end
         ST_EXP_MUL: begin
            if (mul_rsp.done) begin
               e_in     = mul_rsp.p[57:24];
               r_in     = EXP2_ONE;
               cnt_in   = 4'd15;
               state_in = ST_EXP2;
            end
         end
         ST_NORM: begin
            // shift up to the leading one, then start squaring the mantissa
            if (norm_ff[46]) begin
               mul_req.start = 1'b1;
               mul_req.a     = 64'(norm_ff[46:16]);
               mul_req.b     = 32'(norm_ff[46:16]);
               frac_in       = '0;
               cnt_in        = '0;
               state_in      = ST_LOG_SQ;
            end else begin
               norm_in = {norm_ff[45:0], 1'b0};
               lead_in = lead_ff - 6'd1;
            end
         end
         ST_LOG_SQ: begin
            if (mul_rsp.done) begin
               frac_in       = frac_next;
               cnt_in        = cnt_ff + 4'd1;
               mul_req.start = 1'b1;
               if (cnt_ff == 4'd15) begin
                  mul_req.a = 64'(log_val);
                  mul_req.b = lambda_ff;
                  state_in  = ST_LOG_MUL;
               end else begin
                  mul_req.a = 64'(m_next);
                  mul_req.b = 32'(m_next);
               end
            end
         end
         ST_LOG_MUL: begin
            if (mul_rsp.done) begin
               e_in     = 34'(mul_rsp.p[52:24]);
               r_in     = EXP2_ONE;
               cnt_in   = 4'd15;
               state_in = ST_EXP2;
            end
         end
         ST_EXP2: begin
            // apply the factor of each set fraction bit, top bit first
            if (e_ff[cnt_ff]) begin
               mul_req.start = 1'b1;
               mul_req.a     = 64'(r_ff);
               mul_req.b     = 32'(FACTORS[cnt_ff]);
               state_in      = ST_EXP2_MUL;
            end else if (cnt_ff == '0) begin
               state_in = ST_EXP2_SHIFT;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
         ST_EXP2_MUL: begin
            if (mul_rsp.done) begin
               r_in = mul_rsp.p[60:30];
               if (cnt_ff == '0) begin
                  state_in = ST_EXP2_SHIFT;
               end else begin
                  cnt_in   = cnt_ff - 4'd1;
                  state_in = ST_EXP2;
               end
            end
         end
         ST_EXP2_SHIFT: begin
            mul_req.start = 1'b1;
            mul_req.a     = 64'(w_ff);
            mul_req.b     = 32'(exp2_val);
            state_in      = ST_SCALE_MUL;
         end
         ST_SCALE_MUL: begin
            if (mul_rsp.done) begin
               v_in     = $signed(48'(mul_rsp.p[47:30]));
               state_in = (kind_ff == KIND_QUERY) ? ST_FINISH : ST_BLEND;
            end
         end
         ST_BLEND: begin
            mul_req.start = 1'b1;
            mul_req.a     = 64'(v_mag);
            mul_req.b     = 32'(f_mag);
            neg_in        = v_ff[47] ^ f[18];
            state_in      = ST_BLEND_MUL;
         end
         ST_BLEND_MUL: begin
            // floor of a signed product: round the magnitude up when negative
            if (mul_rsp.done) begin
               if (neg_ff) begin
                  v_in = $signed(48'(boost_ff)) - $signed(48'(blend_ceil[57:16]));
               end else begin
                  v_in = $signed(48'(boost_ff)) + $signed(48'(mul_rsp.p[57:16]));
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (v_ff <= $signed(48'(cutoff_ff))) begin
               res_in = '0;
            end else if (v_ff > $signed(48'(WMAX))) begin
               res_in = WMAX;
            end else begin
               res_in = v_ff[16:0];
            end
            state_in = (kind_ff == KIND_QUERY) ? ST_DONE : ST_WRITE_AB;
         end
         ST_WRITE_AB: begin
            mem_we   = 1'b1;
            mem_addr = ab;
            state_in = ST_WRITE_BA;
         end
         ST_WRITE_BA: begin
            mem_we   = 1'b1;
            mem_addr = ba;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = err_ff ? ERR_WEIGHT : {1'b0, res_ff};
               rsp_err_in    = err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control, configuration and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_EXP;
         boost_ff     <= ONE_Q16;
         cutoff_ff    <= '0;
         lambda_ff    <= '0;
         unit_ff      <= 12'd1;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         boost_ff     <= boost_in;
         cutoff_ff    <= cutoff_in;
         lambda_ff    <= lambda_in;
         unit_ff      <= unit_in;
      end
      kind_ff       <= kind_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      now_ff        <= now_in;
      w_ff          <= w_in;
      v_ff          <= v_in;
      norm_ff       <= norm_in;
      lead_ff       <= lead_in;
      frac_ff       <= frac_in;
      cnt_ff        <= cnt_in;
      e_ff          <= e_in;
      r_ff          <= r_in;
      neg_ff        <= neg_in;
      res_ff        <= res_in;
      err_ff        <= err_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_err_ff    <= rsp_err_in;
   end

   // Edge memory: one write port, registered read of the forward entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_q_ff <= mem[ab];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_weight_ff};
   assign rsp_tuser  = rsp_err_ff;

   // A time error always carries the error weight
   a_err_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[17:0] == ERR_WEIGHT)
      else $error("time error without error weight");

   // Regular results are never negative
   a_weight_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tdata[17])
      else $error("negative weight without time error");

   // One item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   // Quotient arrives only while the sequencer waits for it
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

endmodule
